[hw/rtl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the WAV stream to PCM16 decoder.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Four-character chunk tags, as they assemble little-endian.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] FMT_FLOAT      = 16'd3;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hfffe;

  localparam logic [31:0] RATE_MIN = 32'd8000;
  localparam logic [31:0] RATE_MAX = 32'd96000;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Reject reasons.
  localparam logic [1:0] RSN_BAD_RIFF   = 2'd0;
  localparam logic [1:0] RSN_FMT_SHORT  = 2'd1;
  localparam logic [1:0] RSN_NO_FMT     = 2'd2;
  localparam logic [1:0] RSN_UNSUPPORTD = 2'd3;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_RIFF = 7'b0000001,
    PH_CHDR = 7'b0000010,
    PH_FMT  = 7'b0000100,
    PH_SKIP = 7'b0001000,
    PH_PAD  = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  // One result word as it travels down the pipeline.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic        last;
    logic [1:0]  reject_reason;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic        is_float;
    logic [31:0] data_length;
    logic        flt_sample;
    logic [31:0] raw;
  } res_t;

endpackage

[hw/rtl/wsp_parser.sv]
// ----------------------------------------------------------------------------
// wsp_parser
// Byte-serial RIFF/WAVE header walker and sample gatherer. Updates its state
// on each accepted byte and produces at most one result word.
// ----------------------------------------------------------------------------
module wsp_parser
  import wsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       new_file,
  output logic       res_valid,
  output res_t       res
);

  phase_t      phase, phase_next, ph_c;
  logic [31:0] pos, pos_next, pos_c;
  logic [31:0] tag, tag_next, tag_c;
  logic [31:0] clen, clen_next, clen_c;
  logic [15:0] fmt, fmt_next, fmt_c;
  logic [15:0] sub, sub_next, sub_c;
  logic [15:0] chans, chans_next, chans_c;
  logic [31:0] rate, rate_next, rate_c;
  logic [15:0] bits, bits_next, bits_c;
  logic        seen, seen_next, seen_c;
  logic [31:0] left, left_next, left_c;
  logic [31:0] gath, gath_next, gath_c;
  logic [2:0]  gcnt, gcnt_next, gcnt_c;

  logic [31:0] lane_b;
  logic [15:0] half_b;
  logic [2:0]  nb;
  logic        pcm_ok, flt_ok;

  // State as seen by this byte: a new file starts from the reset state.
  always_comb begin
    if (new_file) begin
      ph_c = PH_RIFF; pos_c = '0; tag_c = '0; clen_c = '0; fmt_c = '0; sub_c = '0;
      chans_c = '0; rate_c = '0; bits_c = '0; seen_c = 1'b0; left_c = '0;
      gath_c = '0; gcnt_c = '0;
    end else begin
      ph_c = phase; pos_c = pos; tag_c = tag; clen_c = clen; fmt_c = fmt;
      sub_c = sub; chans_c = chans; rate_c = rate; bits_c = bits; seen_c = seen;
      left_c = left; gath_c = gath; gcnt_c = gcnt;
    end
  end

  // One parse step.
  always_comb begin
    phase_next = ph_c; pos_next = pos_c; tag_next = tag_c; clen_next = clen_c;
    fmt_next = fmt_c; sub_next = sub_c; chans_next = chans_c; rate_next = rate_c;
    bits_next = bits_c; seen_next = seen_c; left_next = left_c; gath_next = gath_c;
    gcnt_next = gcnt_c;
    res_valid = 1'b0;
    res = '0;
    lane_b = {24'd0, data_byte} << {pos_c[1:0], 3'b000};
    half_b = {8'd0, data_byte} << {pos_c[0], 3'b000};
    nb = bits_c[5:3];
    pcm_ok = fmt_c == FMT_PCM && (bits_c == 16'd8 || bits_c == 16'd16 ||
             bits_c == 16'd24 || bits_c == 16'd32);
    flt_ok = fmt_c == FMT_FLOAT && bits_c == 16'd32;

    case (ph_c)
      PH_RIFF: begin
        if (pos_c < 32'd4 || (pos_c >= 32'd8 && pos_c < 32'd12)) begin
          tag_next = tag_c | lane_b;
        end
        pos_next = pos_c + 32'd1;
        if (pos_c == 32'd3) begin
          if (tag_next != TAG_RIFF) begin
            phase_next = PH_DONE;
            res_valid = 1'b1; res.kind = KIND_REJECT; res.reject_reason = RSN_BAD_RIFF;
          end else begin
            tag_next = '0;
          end
        end else if (pos_c == 32'd11) begin
          if (tag_next != TAG_WAVE) begin
            phase_next = PH_DONE;
            res_valid = 1'b1; res.kind = KIND_REJECT; res.reject_reason = RSN_BAD_RIFF;
          end else begin
            phase_next = PH_CHDR; pos_next = '0; tag_next = '0; clen_next = '0;
          end
        end
      end
      PH_CHDR: begin
        if (pos_c < 32'd4) tag_next = tag_c | lane_b;
        else clen_next = clen_c | lane_b;
        pos_next = pos_c + 32'd1;
        if (pos_c >= 32'd7) begin
          pos_next = '0;
          if (tag_next == TAG_FMT) begin
            if (clen_next < 32'd16) begin
              phase_next = PH_DONE;
              res_valid = 1'b1; res.kind = KIND_REJECT; res.reject_reason = RSN_FMT_SHORT;
            end else begin
              phase_next = PH_FMT;
            end
          end else if (tag_next == TAG_DATA) begin
            res_valid = 1'b1;
            if (!seen_c) begin
              phase_next = PH_DONE;
              res.kind = KIND_REJECT; res.reject_reason = RSN_NO_FMT;
            end else if (!(pcm_ok || flt_ok) || (chans_c != 16'd1 && chans_c != 16'd2) ||
                         rate_c < RATE_MIN || rate_c > RATE_MAX) begin
              phase_next = PH_DONE;
              res.kind = KIND_REJECT; res.reject_reason = RSN_UNSUPPORTD;
            end else begin
              left_next = clen_next; gath_next = '0; gcnt_next = '0;
              phase_next = (clen_next == '0) ? PH_DONE : PH_DATA;
              res.kind = KIND_ACCEPT; res.last = clen_next == '0;
              res.channel_count = chans_c; res.rate_hz = rate_c;
              res.sample_bits = bits_c; res.is_float = flt_ok;
              res.data_length = clen_next;
            end
          end else if (clen_next == '0) begin
            phase_next = PH_CHDR; tag_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (pos_c < 32'd2) fmt_next = (fmt_c & ~(16'hff << {pos_c[0], 3'b000})) | half_b;
        else if (pos_c < 32'd4)
          chans_next = (chans_c & ~(16'hff << {pos_c[0], 3'b000})) | half_b;
        else if (pos_c < 32'd8)
          rate_next = (rate_c & ~(32'hff << {pos_c[1:0], 3'b000})) | lane_b;
        else if (pos_c == 32'd14 || pos_c == 32'd15)
          bits_next = (bits_c & ~(16'hff << {pos_c[0], 3'b000})) | half_b;
        else if (pos_c == 32'd24 || pos_c == 32'd25)
          sub_next = (sub_c & ~(16'hff << {pos_c[0], 3'b000})) | half_b;
        pos_next = pos_c + 32'd1;
        clen_next = clen_c - 32'd1;
        if (clen_next == '0) begin
          if (fmt_next == FMT_EXTENSIBLE && pos_next >= 32'd40) fmt_next = sub_next;
          seen_next = 1'b1;
          if (pos_next[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_CHDR; pos_next = '0; tag_next = '0;
          end
        end
      end
      PH_SKIP: begin
        pos_next = pos_c + 32'd1;
        clen_next = clen_c - 32'd1;
        if (clen_next == '0) begin
          if (pos_next[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_CHDR; pos_next = '0; tag_next = '0;
          end
        end
      end
      PH_PAD: begin
        phase_next = PH_CHDR; pos_next = '0; tag_next = '0; clen_next = '0;
      end
      PH_DATA: begin
        left_next = left_c - 32'd1;
        gath_next = gath_c | ({24'd0, data_byte} << {gcnt_c[1:0], 3'b000});
        gcnt_next = gcnt_c + 3'd1;
        if (gcnt_next >= nb) begin
          res_valid = 1'b1;
          res.kind = KIND_SAMPLE;
          res.last = left_next == '0;
          res.is_float = fmt_c == FMT_FLOAT;
          res.flt_sample = fmt_c == FMT_FLOAT;
          res.raw = gath_next;
          case (nb)
            3'd1:    res.sample = {gath_next[7:0] ^ 8'h80, 8'h00};
            3'd2:    res.sample = gath_next[15:0];
            3'd3:    res.sample = gath_next[23:8];
            default: res.sample = gath_next[31:16];
          endcase
          gath_next = '0; gcnt_next = '0;
          if (left_next == '0) phase_next = PH_DONE;
        end else if (left_next == '0) begin
          phase_next = PH_DONE;
          res_valid = 1'b1; res.kind = KIND_END; res.last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF; pos <= '0; tag <= '0; clen <= '0; fmt <= '0; sub <= '0;
      chans <= '0; rate <= '0; bits <= '0; seen <= 1'b0; left <= '0;
      gath <= '0; gcnt <= '0;
    end else if (take) begin
      phase <= phase_next; pos <= pos_next; tag <= tag_next; clen <= clen_next;
      fmt <= fmt_next; sub <= sub_next; chans <= chans_next; rate <= rate_next;
      bits <= bits_next; seen <= seen_next; left <= left_next; gath <= gath_next;
      gcnt <= gcnt_next;
    end
  end

endmodule

[hw/rtl/wsp_float_cvt.sv]
// ----------------------------------------------------------------------------
// wsp_float_cvt
// Pipelined binary32 to int16 conversion: clamp, times 32767 rounded to
// 24 significant bits nearest-even, truncate. Two register stages inside;
// the result is combinational from the second stage.
// ----------------------------------------------------------------------------
module wsp_float_cvt
  import wsp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] raw,
  output logic [15:0] sample
);

  // Stage A: decode and multiply.
  logic [7:0]  e;
  logic [23:0] mm;
  logic [38:0] prod_next, prod_a, prod_b;
  logic [7:0]  shx_next, shx_a, shx_b;
  logic        neg_a, nan_a, sat_a, neg_b, nan_b, sat_b;

  always_comb begin
    e = raw[30:23];
    mm = (e == 8'd0) ? {1'b0, raw[22:0]} : {1'b1, raw[22:0]};
    shx_next = (e == 8'd0) ? 8'd149 : 8'd150 - e;
    prod_next = {15'd0, mm} * 39'd32767;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= prod_next;
      shx_a <= shx_next;
      neg_a <= raw[31];
      nan_a <= e == 8'hff && raw[22:0] != '0;
      sat_a <= e >= 8'd127;
    end
  end

  // Stage B: find the bit length of the product.
  logic [5:0] len;
  logic [3:0] sh_next, sh_b;

  always_comb begin
    len = '0;
    for (int i = 0; i < 39; i++) begin
      if (prod_a[i]) len = 6'(i + 1);
    end
    sh_next = (len > 6'd24) ? 4'(len - 6'd24) : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b <= prod_a; shx_b <= shx_a; sh_b <= sh_next;
      neg_b <= neg_a; nan_b <= nan_a; sat_b <= sat_a;
    end
  end

  // Round to 24 bits, then scale down and apply the sign.
  logic [39:0] q, rem, half, r, scaled;
  logic        up;
  logic [15:0] mag;

  always_comb begin
    q = {1'b0, prod_b} >> sh_b;
    rem = {1'b0, prod_b} & ((40'd1 << sh_b) - 40'd1);
    half = (sh_b == 4'd0) ? 40'd0 : (40'd1 << (sh_b - 4'd1));
    up = sh_b != 4'd0 && (rem > half || (rem == half && q[0]));
    r = (q + {39'd0, up}) << sh_b;
    scaled = r >> shx_b;
    mag = (shx_b >= 8'd40) ? 16'd0 : scaled[15:0];
    if (sat_b) mag = 16'd32767;
    if (nan_b) sample = 16'd0;
    else if (neg_b) sample = 16'd0 - mag;
    else sample = mag;
  end

endmodule

[hw/rtl/wav_stream_to_pcm16.sv]
// ----------------------------------------------------------------------------
// wav_stream_to_pcm16
// WAV byte stream parser and PCM decoder producing int16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one file byte per word with
//   new_file marking the first byte of a file. The output channel
//   (out_valid/out_ready) carries result words: samples, header accept or
//   reject reports, and the end-of-data marker.
//   One byte is accepted per cycle while the output is not stalled. A byte
//   that yields a result reaches the output through registers in order: the
//   parse register loads at the edge that accepts it, then two stages of the
//   float multiply and normalize path, then the output register. Integer
//   results travel the same stages so order is kept.
//   When the receiver stalls, the whole pipeline holds and in_ready drops in
//   the same cycle; bytes are taken again as soon as the output word is taken.
//   Reset clears the parser to the RIFF header phase and empties the
//   pipeline; new_file does the same for parser state on its byte.
// ----------------------------------------------------------------------------
module wav_stream_to_pcm16
  import wsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               new_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] sample,
  output logic               last,
  output logic [1:0]         reject_reason,
  output logic [15:0]        channel_count,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic               is_float,
  output logic [31:0]        data_length
);

  logic  adv, take, p_valid;
  res_t  p_res, s1, s2, s3, o;
  logic  v1, v2, v3;
  logic [15:0] flt_sample;

  // Pipeline moves whenever the output register is free or being emptied.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign take = in_valid && adv;

  wsp_parser u_parser (
    .clk(clk), .rst(rst), .take(take), .data_byte(data_byte), .new_file(new_file),
    .res_valid(p_valid), .res(p_res)
  );

  wsp_float_cvt u_cvt (
    .clk(clk), .en(adv), .raw(s1.raw), .sample(flt_sample)
  );

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= take && p_valid; v2 <= v1; v3 <= v2; out_valid <= v3;
    end
  end

  // Result words follow the float path stage by stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= p_res; s2 <= s1; s3 <= s2;
      o <= s3;
      if (s3.flt_sample) o.sample <= flt_sample;
    end
  end

  assign kind = o.kind;
  assign sample = o.sample;
  assign last = o.last;
  assign reject_reason = o.reject_reason;
  assign channel_count = o.channel_count;
  assign rate_hz = o.rate_hz;
  assign sample_bits = o.sample_bits;
  assign is_float = o.is_float;
  assign data_length = o.data_length;

  // Checks.
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output free");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REJECT) |-> (channel_count == '0 && !last && !is_float))
    else $error("reject word carries header fields");

  a_accept_nosample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_SAMPLE) |-> sample == '0)
    else $error("non-sample word carries a sample");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives WAV files byte by byte into wav_stream_to_pcm16 and checks every
// result word against a local model of the parser and sample converter.
// ----------------------------------------------------------------------------
module testbench
  import wsp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic        last;
    logic [1:0]  reason;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic        isf;
    logic [31:0] dlen;
  } word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       nf;
  } byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'd0;
  logic new_file = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic signed [15:0] sample;
  logic last;
  logic [1:0] reject_reason;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [15:0] sample_bits;
  logic is_float;
  logic [31:0] data_length;

  wav_stream_to_pcm16 dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_t pending_bytes[$];
  word_t expected_words[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  // Handshake flag captured at the rising edge for the driver.
  logic in_taken = 1'b0;
  int drv_idle = 0;
  int rcv_idle = 0;

  // Parser state of the model.
  phase_t ph;
  logic [31:0] pos, tag, clen, rate_h, left, gather;
  logic [15:0] ftag, subtag, chans_h, bits_h;
  logic fseen;
  logic [2:0] gcount;

  function automatic void model_reset();
    ph = PH_RIFF; pos = 0; tag = 0; clen = 0; ftag = 0; subtag = 0;
    chans_h = 0; rate_h = 0; bits_h = 0; fseen = 0; left = 0; gather = 0;
    gcount = 0;
  endfunction

  // Clamp, scale by 32767 rounded to 24 bits, truncate; NaN gives zero.
  function automatic logic [15:0] float_to_pcm(logic [31:0] w);
    logic [7:0] e;
    logic [23:0] m;
    logic [63:0] p, q, rem, half, r;
    int len, sh, ex;
    logic [31:0] mag;
    e = w[30:23];
    m = {1'b0, w[22:0]};
    if (e == 8'hff && m != 0) return 16'd0;
    if (e >= 8'd127) mag = 32767;
    else begin
      if (e == 0) ex = -149;
      else begin
        m[23] = 1'b1;
        ex = int'(e) - 150;
      end
      p = 64'(m) * 64'd32767;
      len = 0;
      while (len < 64 && (p >> len) != 0) len++;
      r = p;
      if (len > 24) begin
        sh = len - 24;
        q = p >> sh;
        rem = p & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        r = q << sh;
      end
      sh = -ex;
      mag = sh >= 64 ? 0 : 32'(r >> sh);
    end
    return w[31] ? 16'(0 - mag) : mag[15:0];
  endfunction

  function automatic void leave_chunk();
    if (pos[0]) begin
      ph = PH_PAD;
      return;
    end
    ph = PH_CHDR; pos = 0; tag = 0; clen = 0;
  endfunction

  function automatic void push_reject(logic [1:0] rsn);
    word_t w;
    ph = PH_DONE;
    w = '0;
    w.kind = KIND_REJECT;
    w.reason = rsn;
    expected_words.push_back(w);
  endfunction

  // Advances the model by one byte and queues any result it causes.
  function automatic void decode_byte(logic [7:0] b, logic nf);
    word_t w;
    logic [31:0] p;
    logic [2:0] nb;
    logic pcm, flt, isf;
    logic [15:0] smp;
    if (nf) model_reset();
    p = pos;
    w = '0;
    case (ph)
      PH_RIFF: begin
        if (p < 4) tag |= 32'(b) << (8 * p);
        else if (p >= 8 && p < 12) tag |= 32'(b) << (8 * (p - 8));
        pos = p + 1;
        if (p == 3) begin
          if (tag != TAG_RIFF) push_reject(RSN_BAD_RIFF);
          else tag = 0;
        end else if (p == 11) begin
          if (tag != TAG_WAVE) push_reject(RSN_BAD_RIFF);
          else begin
            ph = PH_CHDR; pos = 0; tag = 0; clen = 0;
          end
        end
      end
      PH_CHDR: begin
        if (p < 4) tag |= 32'(b) << (8 * p);
        else clen |= 32'(b) << (8 * ((p - 4) & 3));
        pos = p + 1;
        if (p >= 7) begin
          pos = 0;
          if (tag == TAG_FMT) begin
            if (clen < 16) push_reject(RSN_FMT_SHORT);
            else ph = PH_FMT;
          end else if (tag == TAG_DATA) begin
            pcm = ftag == FMT_PCM && (bits_h == 8 || bits_h == 16 || bits_h == 24 ||
                                      bits_h == 32);
            flt = ftag == FMT_FLOAT && bits_h == 32;
            if (!fseen) push_reject(RSN_NO_FMT);
            else if (!(pcm || flt) || (chans_h != 1 && chans_h != 2) ||
                     rate_h < RATE_MIN || rate_h > RATE_MAX)
              push_reject(RSN_UNSUPPORTD);
            else begin
              left = clen; gather = 0; gcount = 0;
              ph = clen == 0 ? PH_DONE : PH_DATA;
              w.kind = KIND_ACCEPT; w.last = clen == 0; w.chans = chans_h;
              w.rate = rate_h; w.bits = bits_h; w.isf = flt; w.dlen = clen;
              expected_words.push_back(w);
            end
          end else if (clen == 0) leave_chunk();
          else ph = PH_SKIP;
        end
      end
      PH_FMT: begin
        if (p < 2) ftag[8*p +: 8] = b;
        else if (p < 4) chans_h[8*(p-2) +: 8] = b;
        else if (p < 8) rate_h[8*(p-4) +: 8] = b;
        else if (p == 14 || p == 15) bits_h[8*(p-14) +: 8] = b;
        else if (p == 24 || p == 25) subtag[8*(p-24) +: 8] = b;
        pos = p + 1;
        clen--;
        if (clen == 0) begin
          if (ftag == FMT_EXTENSIBLE && pos >= 40) ftag = subtag;
          fseen = 1'b1;
          leave_chunk();
        end
      end
      PH_SKIP: begin
        pos = p + 1;
        clen--;
        if (clen == 0) leave_chunk();
      end
      PH_PAD: begin
        pos = 0;
        leave_chunk();
      end
      PH_DATA: begin
        left--;
        gather |= 32'(b) << (8 * gcount[1:0]);
        gcount = gcount + 1;
        nb = bits_h[5:3];
        isf = ftag == FMT_FLOAT;
        if (gcount >= nb) begin
          if (isf) smp = float_to_pcm(gather);
          else if (nb == 1) smp = {gather[7:0] ^ 8'h80, 8'h00};
          else if (nb == 2) smp = gather[15:0];
          else if (nb == 3) smp = gather[23:8];
          else smp = gather[31:16];
          gather = 0; gcount = 0;
          if (left == 0) ph = PH_DONE;
          w.kind = KIND_SAMPLE; w.sample = smp; w.last = left == 0; w.isf = isf;
          expected_words.push_back(w);
        end else if (left == 0) begin
          ph = PH_DONE;
          w.kind = KIND_END; w.last = 1'b1;
          expected_words.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus building blocks.
  task automatic put_byte(logic [7:0] b, logic nf = 1'b0);
    byte_t x;
    x.b = b; x.nf = nf;
    pending_bytes.push_back(x);
  endtask

  task automatic put_word(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
  endtask

  task automatic put_riff(logic [31:0] riff = TAG_RIFF, logic [31:0] wave = TAG_WAVE);
    put_byte(riff[7:0], 1'b1);
    put_byte(riff[15:8]); put_byte(riff[23:16]); put_byte(riff[31:24]);
    put_word($urandom, 4);
    put_word(wave, 4);
  endtask

  // A fmt chunk of length flen; bytes beyond the known fields are random.
  task automatic put_fmt(int flen, logic [15:0] ft, logic [15:0] ch, logic [31:0] rt,
                         logic [15:0] bt, logic [15:0] sub);
    logic [7:0] b;
    put_word(TAG_FMT, 4);
    put_word(flen, 4);
    for (int i = 0; i < flen; i++) begin
      b = $urandom;
      if (i < 2) b = ft[8*i +: 8];
      else if (i < 4) b = ch[8*(i-2) +: 8];
      else if (i < 8) b = rt[8*(i-4) +: 8];
      else if (i == 14 || i == 15) b = bt[8*(i-14) +: 8];
      else if (i == 24 || i == 25) b = sub[8*(i-24) +: 8];
      put_byte(b);
    end
    if (flen % 2) put_byte($urandom);
  endtask

  task automatic put_skip(int slen);
    put_word($urandom, 4);
    put_word(slen, 4);
    for (int i = 0; i < slen + (slen % 2); i++) put_byte($urandom);
  endtask

  task automatic put_data(int dlen, int nbytes);
    put_word(TAG_DATA, 4);
    put_word(dlen, 4);
    for (int i = 0; i < nbytes; i++) put_byte($urandom);
  endtask

  // Interesting float encodings for the sample payload.
  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 7))
      0: return 32'h7fc00001;
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7f800000};
      2: return {1'($urandom), 8'd127, 23'($urandom)};
      3: return {1'($urandom), 8'd0, 23'($urandom)};
      4: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic put_float_data(int n);
    put_word(TAG_DATA, 4);
    put_word(4 * n, 4);
    for (int i = 0; i < n; i++) put_word(pick_float(), 4);
  endtask

  // One randomly shaped file, mostly well formed.
  task automatic put_random_file();
    int sel, bits, ch, flen, n;
    logic [31:0] rt;
    logic [15:0] ft;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      put_riff($urandom, TAG_WAVE);
      for (int i = 0; i < 4; i++) put_byte($urandom);
      return;
    end
    if (sel == 1) begin
      put_riff(TAG_RIFF, $urandom);
      return;
    end
    put_riff();
    if (sel == 2) begin
      put_data(8, 8);
      return;
    end
    if (sel == 3) begin
      put_word(TAG_FMT, 4);
      put_word($urandom_range(0, 15), 4);
      return;
    end
    if ($urandom_range(0, 3) == 0) put_skip($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0: bits = 8;
      1: bits = 16;
      2: bits = 24;
      default: bits = 32;
    endcase
    ft = FMT_PCM;
    if (bits == 32 && $urandom_range(0, 1)) ft = FMT_FLOAT;
    ch = $urandom_range(1, 2);
    rt = $urandom_range(8000, 96000);
    if (sel == 4) begin
      case ($urandom_range(0, 4))
        0: rt = $urandom_range(0, 7999);
        1: rt = $urandom_range(96001, 200000);
        2: ch = $urandom_range(0, 1) ? 0 : 3;
        3: bits = 12;
        default: ft = $urandom;
      endcase
    end
    flen = 16;
    if ($urandom_range(0, 3) == 0) flen = $urandom_range(17, 44);
    if (flen >= 40 && $urandom_range(0, 1))
      put_fmt(flen, FMT_EXTENSIBLE, ch, rt, bits, ft);
    else
      put_fmt(flen, ft, ch, rt, bits, $urandom);
    if ($urandom_range(0, 4) == 0) put_skip($urandom_range(0, 3));
    n = $urandom_range(0, 8) * (bits / 8);
    if ($urandom_range(0, 4) == 0) n = n + $urandom_range(1, bits / 8 - 1 + 1) - 1;
    if (ft == FMT_FLOAT && sel != 4) begin
      put_float_data(n / 4);
    end else begin
      put_data(n, $urandom_range(0, 5) == 0 ? n + $urandom_range(1, 4) : n);
      if ($urandom_range(0, 9) == 0) put_word(TAG_DATA, 2);
    end
    if ($urandom_range(0, 9) == 0) put_byte($urandom);
  endtask

  // Driver: presents words on the falling edge, random idle bursts.
  always @(negedge clk) begin
    byte_t x;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (drv_idle > 0) begin
          drv_idle--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          drv_idle = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          x = pending_bytes.pop_front();
          data_byte <= x.b;
          new_file <= x.nf;
          in_valid <= 1'b1;
          decode_byte(x.b, x.nf);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (rcv_idle > 0) begin
        rcv_idle--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rcv_idle = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    word_t got, want;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      got = {kind, sample, last, reject_reason, channel_count, rate_hz, sample_bits,
             is_float, data_length};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Directed files: bad tags, short fmt, data before fmt, empty data,
    // partial trailing sample, extensible tag, two fmt chunks, early end.
    put_riff(32'h46464953);
    put_riff(TAG_RIFF, 32'h45564158);
    put_riff(); put_word(TAG_FMT, 4); put_word(15, 4);
    put_riff(); put_data(4, 4);
    put_riff(); put_fmt(16, FMT_PCM, 2, 96000, 16, 0); put_data(0, 3);
    put_riff(); put_fmt(16, FMT_PCM, 1, 8000, 8, 0); put_data(2, 2);
    put_byte(8'h00); put_byte(8'hff);
    put_riff(); put_skip(3); put_fmt(17, FMT_PCM, 1, 44100, 24, 0); put_data(5, 5);
    put_riff(); put_fmt(40, FMT_EXTENSIBLE, 2, 48000, 32, FMT_FLOAT); put_float_data(6);
    put_riff(); put_fmt(16, FMT_FLOAT, 1, 22050, 32, 0);
    put_fmt(16, FMT_PCM, 1, 22050, 32, 0); put_data(8, 8);
    put_riff(); put_fmt(16, 16'hffff, 16'hffff, 32'hffffffff, 16'hffff, 0); put_data(0, 0);
    put_riff(); put_fmt(16, FMT_PCM, 1, 8000, 16, 0);
    while (pending_bytes.size() < 900) put_random_file();
    wait (pending_bytes.size() < 200);
    calm = 1'b1;
    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_parser.sv
hw/rtl/wsp_float_cvt.sv
hw/rtl/wav_stream_to_pcm16.sv
test/testbench.sv
